// ===== design/bep_pkg.sv =====
// Package for the beacon element parser: element tags, field widths,
// result kinds and the cipher/AKM code tables. No dependencies.
`timescale 1ns / 1ps

package bep_pkg;

    // Default size of the kept SSID.
    localparam int ESSID_MAX_DEF = 32;

    // Element tag numbers.
    localparam logic [7:0] TAG_SSID    = 8'h00;
    localparam logic [7:0] TAG_RATES   = 8'h01;
    localparam logic [7:0] TAG_CHANNEL = 8'h03;
    localparam logic [7:0] TAG_RSN     = 8'h30;
    localparam logic [7:0] TAG_XRATES  = 8'h32;

    // Body offsets of the pairwise cipher and AKM suite type bytes in RSN.
    localparam logic [7:0] RSN_CIPHER_POS = 8'd11;
    localparam logic [7:0] RSN_AKM_POS    = 8'd17;
    localparam logic [7:0] RSN_MIN_LEN    = 8'd4;

    // Suite type bytes.
    localparam logic [7:0] SUITE_TKIP = 8'h02;
    localparam logic [7:0] SUITE_CCMP = 8'h04;
    localparam logic [7:0] AKM_EAP    = 8'h01;
    localparam logic [7:0] AKM_PSK    = 8'h02;

    // Reported security kinds.
    localparam logic [1:0] CIPHER_UNKNOWN = 2'd0;
    localparam logic [1:0] CIPHER_CCMP    = 2'd1;
    localparam logic [1:0] CIPHER_TKIP    = 2'd2;
    localparam logic [1:0] AUTH_UNKNOWN   = 2'd0;
    localparam logic [1:0] AUTH_PSK       = 2'd1;
    localparam logic [1:0] AUTH_EAP       = 2'd2;

    // Result kinds carried on tuser.
    localparam logic KIND_SSID    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Output word width: 35 bits of fields padded to whole bytes.
    localparam int OUT_DATA_W = 40;
    localparam int SSID_LEN_W = 6;

    function automatic logic [1:0] cipher_code(input logic [7:0] b);
        logic [1:0] c;
        if (b == SUITE_CCMP) begin
            c = CIPHER_CCMP;
        end else if (b == SUITE_TKIP) begin
            c = CIPHER_TKIP;
        end else begin
            c = CIPHER_UNKNOWN;
        end
        return c;
    endfunction

    function automatic logic [1:0] akm_code(input logic [7:0] b);
        logic [1:0] c;
        if (b == AKM_PSK) begin
            c = AUTH_PSK;
        end else if (b == AKM_EAP) begin
            c = AUTH_EAP;
        end else begin
            c = AUTH_UNKNOWN;
        end
        return c;
    endfunction

endpackage

// ===== design/bep_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module bep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/beacon_element_parser.sv =====
// Beacon element parser top level: tag/length walker, two-bank SSID store
// and result drain. Depends on bep_pkg and bep_ram.
`timescale 1ns / 1ps

// Usage
// Slave stream: one tagged-parameter byte per word in tdata, tlast on the
// final byte of the frame. Bytes are taken one per cycle while tready is high.
// Master stream: at frame end the block sends one word per kept SSID byte
// (tuser = 0) and then one summary word (tuser = 1, tlast = 1). Every word
// carries the frame's summary fields.
// The first result of a frame passes the drain's RAM read stage and output
// register after its final byte is accepted; the drain then sends one word
// per cycle when not stalled, so a frame yields ssid_length + 1 words.
// The SSID store has two banks: the next frame is parsed into one bank while
// the previous frame is drained from the other. The final byte of a frame is
// held off (tready low while tlast is high) until the previous frame's
// summary word has left the drain.
// A stall on the master side holds the output register and then the RAM
// read stage; parsing goes on until the next frame's final byte.
// Reset (synchronous, active low) clears the parse state and empties the
// drain; the SSID store needs no clearing.
module beacon_element_parser #(
    parameter int ESSID_MAX = bep_pkg::ESSID_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // data_byte[7:0]
    input  logic                          i_s_tlast,  // frame_end
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // ssid_byte[7:0], ssid_length[13:8], ssid_truncated[14],
    // channel_number[22:15], max_rate_mbps[29:23], rsn_present[30],
    // cipher_kind[32:31], auth_kind[34:33], zero pad[39:35]
    output logic [bep_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tuser,  // result_kind
    output logic                          o_m_tlast   // run_last
);

    localparam int CW    = $clog2(ESSID_MAX + 1);
    localparam int DEPTH = 2 * ESSID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] BANK_OFS = AW'(ESSID_MAX);
    localparam logic [8:0]    EMAX9    = 9'(ESSID_MAX);

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    // Parse state.
    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_bidx, n_bidx;
    logic [7:0]  r_emax, n_emax;
    logic [CW-1:0] r_count, n_count;
    logic        r_ovf, n_ovf;
    logic [7:0]  r_chan, n_chan;
    logic [6:0]  r_rate, n_rate;
    logic        r_rsn, n_rsn;
    logic [1:0]  r_cipher, n_cipher;
    logic [1:0]  r_auth, n_auth;
    logic        r_wr_bank, n_wr_bank;

    // Frame snapshot used by the drain.
    logic [CW-1:0] r_sn_count, n_sn_count;
    logic        r_sn_ovf, n_sn_ovf;
    logic [7:0]  r_sn_chan, n_sn_chan;
    logic [6:0]  r_sn_rate, n_sn_rate;
    logic        r_sn_rsn, n_sn_rsn;
    logic [1:0]  r_sn_cipher, n_sn_cipher;
    logic [1:0]  r_sn_auth, n_sn_auth;
    logic        r_rd_bank, n_rd_bank;

    // Drain control.
    logic        r_busy, n_busy;
    logic        r_sum_issued, n_sum_issued;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic        r_q_valid, n_q_valid;
    logic        r_q_kind, n_q_kind;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [bep_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic        r_out_kind, n_out_kind;

    logic          s_acc;
    logic          q_move;
    logic          issue_ok;
    logic [7:0]    new_emax;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign o_s_tready = !(r_busy && i_s_tlast);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign q_move     = r_q_valid && (!r_out_valid || i_m_tready);
    assign issue_ok   = r_busy && !r_sum_issued && (!r_q_valid || q_move);

    assign wr_addr  = AW'(r_bidx) + (r_wr_bank ? BANK_OFS : '0);
    assign rd_addr  = AW'(r_rd_idx) + (r_rd_bank ? BANK_OFS : '0);
    assign new_emax = ((r_bidx == 8'd0) || (i_s_tdata > r_emax)) ? i_s_tdata : r_emax;

    always_comb begin
        n_phase      = r_phase;
        n_tag        = r_tag;
        n_len        = r_len;
        n_bidx       = r_bidx;
        n_emax       = r_emax;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_chan       = r_chan;
        n_rate       = r_rate;
        n_rsn        = r_rsn;
        n_cipher     = r_cipher;
        n_auth       = r_auth;
        n_wr_bank    = r_wr_bank;
        n_sn_count   = r_sn_count;
        n_sn_ovf     = r_sn_ovf;
        n_sn_chan    = r_sn_chan;
        n_sn_rate    = r_sn_rate;
        n_sn_rsn     = r_sn_rsn;
        n_sn_cipher  = r_sn_cipher;
        n_sn_auth    = r_sn_auth;
        n_rd_bank    = r_rd_bank;
        n_busy       = r_busy;
        n_sum_issued = r_sum_issued;
        n_rd_idx     = r_rd_idx;
        n_q_valid    = r_q_valid;
        n_q_kind     = r_q_kind;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_kind   = r_out_kind;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        if (s_acc) begin
            unique case (r_phase)
                PH_TAG: begin
                    n_tag   = i_s_tdata;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len  = i_s_tdata;
                    n_bidx = 8'd0;
                    n_emax = 8'd0;
                    if (r_tag == bep_pkg::TAG_SSID) begin
                        n_count = '0;
                        n_ovf   = ({1'b0, i_s_tdata} > EMAX9);
                    end
                    if (r_tag == bep_pkg::TAG_RSN && i_s_tdata >= bep_pkg::RSN_MIN_LEN) begin
                        n_rsn = 1'b1;
                    end
                    n_phase = (i_s_tdata != 8'd0) ? PH_BODY : PH_TAG;
                end
                default: begin
                    // Body byte; an unused phase code is handled the same way.
                    if (r_tag == bep_pkg::TAG_SSID) begin
                        if ({1'b0, r_bidx} < EMAX9) begin
                            wr_en   = 1'b1;
                            n_count = CW'({1'b0, r_bidx} + 9'd1);
                        end
                    end else if (r_tag == bep_pkg::TAG_CHANNEL) begin
                        if (r_bidx == 8'd0) begin
                            n_chan = i_s_tdata;
                        end
                    end else if (r_tag == bep_pkg::TAG_RATES
                                 || r_tag == bep_pkg::TAG_XRATES) begin
                        n_emax = new_emax;
                        if (r_tag == bep_pkg::TAG_XRATES) begin
                            n_rate = new_emax[7:1];
                        end else if (new_emax[7:1] > r_rate) begin
                            n_rate = new_emax[7:1];
                        end
                    end else if (r_tag == bep_pkg::TAG_RSN) begin
                        if (r_bidx == bep_pkg::RSN_CIPHER_POS) begin
                            n_cipher = bep_pkg::cipher_code(i_s_tdata);
                        end else if (r_bidx == bep_pkg::RSN_AKM_POS) begin
                            n_auth = bep_pkg::akm_code(i_s_tdata);
                        end
                    end
                    n_bidx = r_bidx + 8'd1;
                    if (n_bidx >= r_len) begin
                        n_phase = PH_TAG;
                    end
                end
            endcase

            if (i_s_tlast) begin
                // Freeze the frame's results for the drain and start afresh.
                n_sn_count   = n_count;
                n_sn_ovf     = n_ovf;
                n_sn_chan    = n_chan;
                n_sn_rate    = n_rate;
                n_sn_rsn     = n_rsn;
                n_sn_cipher  = n_cipher;
                n_sn_auth    = n_auth;
                n_rd_bank    = r_wr_bank;
                n_wr_bank    = !r_wr_bank;
                n_busy       = 1'b1;
                n_sum_issued = 1'b0;
                n_rd_idx     = '0;
                n_phase      = PH_TAG;
                n_tag        = 8'd0;
                n_len        = 8'd0;
                n_bidx       = 8'd0;
                n_emax       = 8'd0;
                n_count      = '0;
                n_ovf        = 1'b0;
                n_chan       = 8'd0;
                n_rate       = 7'd0;
                n_rsn        = 1'b0;
                n_cipher     = 2'd0;
                n_auth       = 2'd0;
            end
        end

        // Output register.
        if (q_move) begin
            n_out_valid = 1'b1;
            n_out_kind  = r_q_kind;
            n_out_data  = {5'd0, r_sn_auth, r_sn_cipher, r_sn_rsn, r_sn_rate, r_sn_chan,
                           r_sn_ovf, bep_pkg::SSID_LEN_W'(r_sn_count),
                           (r_q_kind == bep_pkg::KIND_SUMMARY) ? 8'd0 : rd_data};
            n_q_valid   = 1'b0;
            if (r_q_kind == bep_pkg::KIND_SUMMARY) begin
                n_busy = 1'b0;
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        // Issue the next SSID read, or the summary token after the last one.
        if (issue_ok) begin
            n_q_valid = 1'b1;
            if (r_rd_idx < r_sn_count) begin
                rd_en    = 1'b1;
                n_q_kind = bep_pkg::KIND_SSID;
                n_rd_idx = r_rd_idx + CW'(1);
            end else begin
                n_q_kind     = bep_pkg::KIND_SUMMARY;
                n_sum_issued = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG;
            r_tag        <= 8'd0;
            r_len        <= 8'd0;
            r_bidx       <= 8'd0;
            r_emax       <= 8'd0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_chan       <= 8'd0;
            r_rate       <= 7'd0;
            r_rsn        <= 1'b0;
            r_cipher     <= 2'd0;
            r_auth       <= 2'd0;
            r_wr_bank    <= 1'b0;
            r_rd_bank    <= 1'b0;
            r_busy       <= 1'b0;
            r_sum_issued <= 1'b0;
            r_rd_idx     <= '0;
            r_q_valid    <= 1'b0;
            r_q_kind     <= bep_pkg::KIND_SSID;
            r_out_valid  <= 1'b0;
            r_out_kind   <= bep_pkg::KIND_SSID;
        end else begin
            r_phase      <= n_phase;
            r_tag        <= n_tag;
            r_len        <= n_len;
            r_bidx       <= n_bidx;
            r_emax       <= n_emax;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_chan       <= n_chan;
            r_rate       <= n_rate;
            r_rsn        <= n_rsn;
            r_cipher     <= n_cipher;
            r_auth       <= n_auth;
            r_wr_bank    <= n_wr_bank;
            r_rd_bank    <= n_rd_bank;
            r_busy       <= n_busy;
            r_sum_issued <= n_sum_issued;
            r_rd_idx     <= n_rd_idx;
            r_q_valid    <= n_q_valid;
            r_q_kind     <= n_q_kind;
            r_out_valid  <= n_out_valid;
            r_out_kind   <= n_out_kind;
        end
        r_sn_count  <= n_sn_count;
        r_sn_ovf    <= n_sn_ovf;
        r_sn_chan   <= n_sn_chan;
        r_sn_rate   <= n_sn_rate;
        r_sn_rsn    <= n_sn_rsn;
        r_sn_cipher <= n_sn_cipher;
        r_sn_auth   <= n_sn_auth;
        r_out_data  <= n_out_data;
    end

    bep_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ssid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = (r_out_kind == bep_pkg::KIND_SUMMARY);

`ifndef SYNTHESIS
    // The drain reads one bank while the parser writes the other.
    a_no_bank_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("SSID write and drain read hit the same entry");

    a_rd_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rd_idx <= r_sn_count))
        else $error("drain read index ran past the kept SSID length");

    a_summary_after_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_sum_issued) |-> (r_rd_idx == r_sn_count))
        else $error("summary issued before all SSID bytes were read");

    a_busy_drops_on_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !n_busy) |-> (q_move && r_q_kind == bep_pkg::KIND_SUMMARY))
        else $error("drain released without passing on the summary word");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for beacon_element_parser: directed and random beacon frames
// with idling on both stream sides, checked against a built-in predictor of the parser.
// Depends on bep_pkg and the beacon_element_parser RTL.
`timescale 1ns / 1ps

typedef enum logic [1:0] {
    WALK_TAG,
    WALK_LEN,
    WALK_BODY
} t_walk_phase;

typedef struct packed {
    logic       kind;
    logic [7:0] ssid_byte;
    logic [5:0] ssid_len;
    logic       truncated;
    logic [7:0] channel;
    logic [6:0] rate;
    logic       rsn;
    logic [1:0] cipher;
    logic [1:0] auth;
    logic       last;
} t_beacon_word;

// Follows the element walk of one frame and queues the words the parser must send.
class beacon_digest;
    t_walk_phase  phase;
    logic [7:0]   tag;
    logic [7:0]   len;
    logic [7:0]   idx;
    logic [7:0]   elem_max;
    logic [7:0]   ssid_mem [bep_pkg::ESSID_MAX_DEF];
    logic [5:0]   ssid_cnt;
    logic         ssid_long;
    logic [7:0]   channel;
    logic [6:0]   rate;
    logic         rsn;
    logic [1:0]   cipher;
    logic [1:0]   auth;
    t_beacon_word pending_words[$];
    int unsigned  mismatches;

    function new();
        mismatches = 0;
        forget_frame();
    endfunction

    // The SSID memory is deliberately left alone: only entries written in the
    // current frame are ever sent.
    function void forget_frame();
        phase     = WALK_TAG;
        tag       = 8'd0;
        len       = 8'd0;
        idx       = 8'd0;
        elem_max  = 8'd0;
        ssid_cnt  = 6'd0;
        ssid_long = 1'b0;
        channel   = 8'd0;
        rate      = 7'd0;
        rsn       = 1'b0;
        cipher    = bep_pkg::CIPHER_UNKNOWN;
        auth      = bep_pkg::AUTH_UNKNOWN;
    endfunction

    function t_beacon_word make_word(logic kind, logic [7:0] sb, logic last);
        t_beacon_word w;
        w.kind      = kind;
        w.ssid_byte = sb;
        w.ssid_len  = ssid_cnt;
        w.truncated = ssid_long;
        w.channel   = channel;
        w.rate      = rate;
        w.rsn       = rsn;
        w.cipher    = cipher;
        w.auth      = auth;
        w.last      = last;
        return w;
    endfunction

    function void walk_body(logic [7:0] b);
        case (tag)
            bep_pkg::TAG_SSID: begin
                if (idx < bep_pkg::ESSID_MAX_DEF) begin
                    ssid_mem[idx] = b;
                    ssid_cnt      = 6'(idx + 8'd1);
                end
            end
            bep_pkg::TAG_CHANNEL: begin
                if (idx == 8'd0) channel = b;
            end
            bep_pkg::TAG_RATES, bep_pkg::TAG_XRATES: begin
                if (idx == 8'd0 || b > elem_max) elem_max = b;
                // The extended rates element overwrites; the basic one only raises.
                if (tag == bep_pkg::TAG_XRATES) begin
                    rate = elem_max[7:1];
                end else if (elem_max[7:1] > rate) begin
                    rate = elem_max[7:1];
                end
            end
            bep_pkg::TAG_RSN: begin
                if (idx == bep_pkg::RSN_CIPHER_POS) begin
                    if (b == bep_pkg::SUITE_CCMP) cipher = bep_pkg::CIPHER_CCMP;
                    else if (b == bep_pkg::SUITE_TKIP) cipher = bep_pkg::CIPHER_TKIP;
                    else cipher = bep_pkg::CIPHER_UNKNOWN;
                end else if (idx == bep_pkg::RSN_AKM_POS) begin
                    if (b == bep_pkg::AKM_PSK) auth = bep_pkg::AUTH_PSK;
                    else if (b == bep_pkg::AKM_EAP) auth = bep_pkg::AUTH_EAP;
                    else auth = bep_pkg::AUTH_UNKNOWN;
                end
            end
            default: ;
        endcase
        idx = idx + 8'd1;
        if (idx >= len) phase = WALK_TAG;
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
        case (phase)
            WALK_TAG: begin
                tag   = b;
                phase = WALK_LEN;
            end
            WALK_LEN: begin
                len      = b;
                idx      = 8'd0;
                elem_max = 8'd0;
                if (tag == bep_pkg::TAG_SSID) begin
                    ssid_cnt  = 6'd0;
                    ssid_long = (b > bep_pkg::ESSID_MAX_DEF);
                end
                if (tag == bep_pkg::TAG_RSN && b >= bep_pkg::RSN_MIN_LEN) rsn = 1'b1;
                phase = (b != 8'd0) ? WALK_BODY : WALK_TAG;
            end
            default: walk_body(b);
        endcase
        if (fin) begin
            for (int i = 0; i < ssid_cnt; i++) begin
                pending_words.push_back(make_word(bep_pkg::KIND_SSID, ssid_mem[i], 1'b0));
            end
            pending_words.push_back(make_word(bep_pkg::KIND_SUMMARY, 8'd0, 1'b1));
            forget_frame();
        end
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    function void check_word(logic [bep_pkg::OUT_DATA_W-1:0] data, logic kind, logic last);
        t_beacon_word want;
        if (pending_words.size() == 0) begin
            mismatches++;
            $display("%0t: expected no word got tdata %h tuser %b tlast %b",
                     $time, data, kind, last);
            return;
        end
        want = pending_words.pop_front();
        compare("result_kind", 8'(want.kind), 8'(kind));
        compare("ssid_byte", want.ssid_byte, data[7:0]);
        compare("ssid_length", 8'(want.ssid_len), 8'(data[13:8]));
        compare("ssid_truncated", 8'(want.truncated), 8'(data[14]));
        compare("channel_number", want.channel, data[22:15]);
        compare("max_rate_mbps", 8'(want.rate), 8'(data[29:23]));
        compare("rsn_present", 8'(want.rsn), 8'(data[30]));
        compare("cipher_kind", 8'(want.cipher), 8'(data[32:31]));
        compare("auth_kind", 8'(want.auth), 8'(data[34:33]));
        compare("tdata padding", 8'd0, 8'(data[bep_pkg::OUT_DATA_W-1:35]));
        compare("run_last", 8'(want.last), 8'(last));
    endfunction
endclass

module testbench;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 160;
    localparam int unsigned PHASE_BYTES  = 130;
    localparam int unsigned SETTLE_TICKS = 8;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [7:0]                     i_s_tdata = 8'd0;
    logic                           i_s_tlast = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [bep_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           o_m_tuser;
    logic                           o_m_tlast;

    beacon_digest book;
    logic [7:0]   frame_bytes[$];
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_idle_pct = 0;
    logic         hold_token = 1'b0;
    logic         hold_seen = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  cycle_count = 0;

    beacon_element_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver readiness; a toggle of hold_token starts a long hold-off.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            book.check_word(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    // Returns at the edge where the word is taken, so the next call may keep
    // tvalid high without a gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        book.take_byte(b, last);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame_bytes.size(); k++) begin
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (book.pending_words.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic push_element(input logic [7:0] tag, input int unsigned len);
        logic [7:0] b;
        frame_bytes.push_back(tag);
        frame_bytes.push_back(len[7:0]);
        for (int unsigned k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            // Bias the suite type bytes towards the codes that the parser knows.
            if (tag == bep_pkg::TAG_RSN && k == bep_pkg::RSN_CIPHER_POS
                && $urandom_range(0, 3) != 0) begin
                b = $urandom_range(0, 1) ? bep_pkg::SUITE_CCMP : bep_pkg::SUITE_TKIP;
            end
            if (tag == bep_pkg::TAG_RSN && k == bep_pkg::RSN_AKM_POS
                && $urandom_range(0, 3) != 0) begin
                b = $urandom_range(0, 1) ? bep_pkg::AKM_PSK : bep_pkg::AKM_EAP;
            end
            frame_bytes.push_back(b);
        end
    endtask

    task automatic build_random_frame();
        int unsigned n_el;
        int unsigned r;
        int unsigned len;
        int unsigned cut;
        frame_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 24);
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_el = $urandom_range(1, 4);
            repeat (n_el) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        r = $urandom_range(0, 99);
                        if (r < 50) len = $urandom_range(0, 6);
                        else if (r < 85) len = $urandom_range(7, 34);
                        else if (r < 97) len = $urandom_range(33, 48);
                        else len = $urandom_range(49, 255);
                        push_element(bep_pkg::TAG_SSID, len);
                    end
                    2: push_element(bep_pkg::TAG_RATES, $urandom_range(1, 8));
                    3: push_element(bep_pkg::TAG_XRATES, $urandom_range(0, 8));
                    4: push_element(bep_pkg::TAG_CHANNEL,
                                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2));
                    5, 6: push_element(bep_pkg::TAG_RSN, $urandom_range(0, 1) ?
                                       $urandom_range(18, 24) : $urandom_range(0, 17));
                    default: push_element(8'($urandom_range(0, 255)), $urandom_range(0, 10));
                endcase
            end
            // Some frames are cut short somewhere inside an element.
            if (frame_bytes.size() > 1 && $urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end
    endtask

    initial begin
        int unsigned sent;
        book = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 28;
        rx_idle_pct <= 48;

        // Extreme bytes, channel and a basic rates element, frame ending inside rates.
        frame_bytes = '{bep_pkg::TAG_SSID, 8'd2, 8'h00, 8'hFF, bep_pkg::TAG_CHANNEL, 8'd1,
                        8'hFF, bep_pkg::TAG_RATES, 8'd2, 8'hFF, 8'h00};
        send_frame();
        // Extended rates overwrite, empty channel element, RSN too short.
        frame_bytes = '{bep_pkg::TAG_XRATES, 8'd1, 8'h02, bep_pkg::TAG_CHANNEL, 8'd0,
                        bep_pkg::TAG_RSN, 8'd3, 8'h01, 8'h00, 8'h00};
        send_frame();
        // Frame ends on a tag byte, then on a length byte.
        frame_bytes = '{bep_pkg::TAG_SSID};
        send_frame();
        frame_bytes = '{bep_pkg::TAG_RSN, bep_pkg::RSN_MIN_LEN};
        send_frame();
        // An empty SSID element clears the one before it.
        frame_bytes = '{bep_pkg::TAG_SSID, 8'd1, 8'h5A, bep_pkg::TAG_SSID, 8'd0};
        send_frame();
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct <= 48;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct <= 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    // Long receiver hold-off while frames keep coming in.
                    hold_token <= ~hold_token;
                end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_random_frame();
                send_frame();
                sent += frame_bytes.size();
            end
            wait_drained();
        end

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
